// ===== hdl/fde_pkg.sv =====
// fde_pkg: shared types and constants for the framebuffer draw engine
// no dependencies
`timescale 1ns / 1ps
package fde_pkg;
   localparam int MaxWidth  = 256;
   localparam int MaxHeight = 256;
   localparam int XW = $clog2(MaxWidth);
   localparam int YW = $clog2(MaxHeight);
   localparam int AW = XW + YW;
   localparam int CW = 12;
   localparam int SW = 13;
   localparam int DIM_W = 9;
   localparam int CSR_AW = 1;
   localparam int PIX_W = 24;

   typedef enum logic [2:0] {
      FUNC_CLEAR = 3'd0,
      FUNC_SET   = 3'd1,
      FUNC_GET   = 3'd2,
      FUNC_RECT  = 3'd3,
      FUNC_CIRC  = 3'd4,
      FUNC_LINE  = 3'd5
   } func_type;

   localparam logic [CSR_AW-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0]           func;
      logic signed [CW-1:0] x_start;
      logic signed [CW-1:0] y_start;
      logic signed [CW-1:0] x_end;
      logic signed [CW-1:0] y_end;
      logic [CW-1:0]        extent_width;
      logic [CW-1:0]        extent_height;
      logic [7:0]           fill_red;
      logic [7:0]           fill_green;
      logic [7:0]           fill_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] read_red;
      logic [7:0] read_green;
      logic [7:0] read_blue;
   } rsp_type;

   // pixel write or read from the sequencer to the store
   typedef struct packed {
      logic          wr;
      logic          rd;
      logic [AW-1:0] addr;
      logic [PIX_W-1:0] data;
   } mem_cmd_type;
endpackage

// ===== hdl/fde_if.sv =====
// fde_if: valid/ready channel carrying a payload struct
// depends on fde_pkg
`timescale 1ns / 1ps
interface fde_req_if;
   import fde_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fde_rsp_if;
   import fde_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fde_store.sv =====
// fde_store: 64k x 24 pixel memory, one access per cycle, registered read
// depends on fde_pkg
`timescale 1ns / 1ps
module fde_store (
   input  logic                     clock,
   input  fde_pkg::mem_cmd_type     cmd,
   output logic [fde_pkg::PIX_W-1:0] rdata
);
   import fde_pkg::*;
   logic [PIX_W-1:0] mem [0:(1<<AW)-1];
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[cmd.addr] <= cmd.data;
      end
      if (cmd.rd) begin
         rdata <= mem[cmd.addr];
      end
   end
endmodule

// ===== hdl/framebuffer_draw_engine_core.sv =====
// framebuffer_draw_engine_core: command sequencer over the pixel store
// depends on fde_pkg, fde_if, fde_store
`timescale 1ns / 1ps
// Usage:
// req carries one drawing command per request: clear, set pixel, get pixel,
// fill rect, fill circle or line, with coordinates, extents and a colour.
// rsp returns one response per command: the pixel colour for get pixel,
// zero for everything else or for a get outside the image.
// csr_we/csr_index/csr_wdata set the active width (0) and height (1);
// write them only while no command is in flight.
// One command is worked at a time. A command that paints scans its pixels:
// rect and clear scan the clipped box, a circle scans its clipped bounding
// box, and a line walks its steps. Get pixel passes through a read state,
// as the store port has a registered read. Set and the unused codes go
// straight to the done state. The single store port sets the pixel rate at
// one a cycle. The response register is loaded from the done state once it
// is free.
// Reset returns to idle with 256 x 256 active size; the store content is
// undefined until written, so clear it first. A stalled rsp holds the
// result in its register; the next request is still taken and worked, and
// its result waits in the done state until the register is free.
module framebuffer_draw_engine_core (
   input  logic                          clock,
   input  logic                          reset,
   fde_req_if.sink                       req,
   fde_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [fde_pkg::CSR_AW-1:0]    csr_index,
   input  logic [fde_pkg::DIM_W-1:0]     csr_wdata
);
   import fde_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_BOX   = 6'b000100,
      ST_LINE  = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [DIM_W-1:0] width_ff, height_ff;
   req_type cmd_ff, cmd_in;
   logic signed [SW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [SW-1:0] x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [SW+2:0] err_ff, err_in;
   logic signed [SW:0] dx_ff, dx_in, dy_ff, dy_in;
   logic sx_ff, sx_in, sy_ff, sy_in, xmaj_ff, xmaj_in, circ_ff, circ_in;
   logic [25:0] lim_ff, lim_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic get_ok_ff, get_ok_in;
   mem_cmd_type mcmd;
   logic [PIX_W-1:0] rdata;

   logic signed [SW-1:0] aw, ah;
   logic signed [SW:0] xs, ys, xe, ye, ew, eh;
   logic signed [SW:0] bx0, by0, bx1, by1;
   logic signed [SW:0] rx, ry;
   logic signed [27:0] rx_sq, ry_sq;
   logic [27:0] d2;
   logic in_img;
   logic [PIX_W-1:0] rgb;

   fde_store u_store (.clock(clock), .cmd(mcmd), .rdata(rdata));

   assign aw = (width_ff > DIM_W'(MaxWidth)) ? SW'(MaxWidth) : SW'(width_ff);
   assign ah = (height_ff > DIM_W'(MaxHeight)) ? SW'(MaxHeight) : SW'(height_ff);
   assign xs = (SW+1)'(cmd_ff.x_start);
   assign ys = (SW+1)'(cmd_ff.y_start);
   assign xe = (SW+1)'(cmd_ff.x_end);
   assign ye = (SW+1)'(cmd_ff.y_end);
   assign ew = (SW+1)'({1'b0, cmd_ff.extent_width});
   assign eh = (SW+1)'({1'b0, cmd_ff.extent_height});
   assign rgb = {cmd_ff.fill_red, cmd_ff.fill_green, cmd_ff.fill_blue};
   assign in_img = (x_ff >= 0) && (x_ff < aw) && (y_ff >= 0) && (y_ff < ah);
   assign rx = (SW+1)'(x_ff) - xs;
   assign ry = (SW+1)'(y_ff) - ys;
   assign rx_sq = 28'(rx) * 28'(rx);
   assign ry_sq = 28'(ry) * 28'(ry);
   assign d2 = $unsigned(rx_sq + ry_sq);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;

   always_comb begin
      unique case (cmd_ff.func)
         FUNC_CLEAR: begin
            bx0 = '0; by0 = '0; bx1 = (SW+1)'(aw); by1 = (SW+1)'(ah);
         end
         FUNC_CIRC: begin
            bx0 = xs - ew; by0 = ys - ew; bx1 = xs + ew + 1; by1 = ys + ew + 1;
         end
         default: begin
            bx0 = xs; by0 = ys; bx1 = xs + ew; by1 = ys + eh;
         end
      endcase
      if (bx0 < 0) bx0 = '0;
      if (by0 < 0) by0 = '0;
      if (bx1 > (SW+1)'(aw)) bx1 = (SW+1)'(aw);
      if (by1 > (SW+1)'(ah)) by1 = (SW+1)'(ah);
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      x_in = x_ff; y_in = y_ff; x0_in = x0_ff; x1_in = x1_ff; y1_in = y1_ff;
      err_in = err_ff; dx_in = dx_ff; dy_in = dy_ff;
      sx_in = sx_ff; sy_in = sy_ff; xmaj_in = xmaj_ff; circ_in = circ_ff;
      lim_in = lim_ff; get_ok_in = get_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      mcmd = '0;
      mcmd.addr = {y_ff[YW-1:0], x_ff[XW-1:0]};
      mcmd.data = rgb;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.data;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            x_in = SW'(xs); y_in = SW'(ys);
            circ_in = (cmd_ff.func == FUNC_CIRC);
            lim_in = 26'(cmd_ff.extent_width) * 26'(cmd_ff.extent_width);
            unique case (cmd_ff.func)
               FUNC_CLEAR, FUNC_RECT, FUNC_CIRC: begin
                  x0_in = SW'(bx0); x1_in = SW'(bx1); y1_in = SW'(by1);
                  x_in = SW'(bx0); y_in = SW'(by0);
                  state_in = (bx0 < bx1 && by0 < by1) ? ST_BOX : ST_DONE;
               end
               FUNC_SET: begin
                  state_in = ST_DONE;
                  mcmd.wr = (xs >= 0) && (xs < (SW+1)'(aw)) && (ys >= 0)
                            && (ys < (SW+1)'(ah));
                  mcmd.addr = {ys[YW-1:0], xs[XW-1:0]};
               end
               FUNC_GET: begin
                  get_ok_in = (xs >= 0) && (xs < (SW+1)'(aw)) && (ys >= 0)
                              && (ys < (SW+1)'(ah));
                  mcmd.rd = 1'b1;
                  mcmd.addr = {ys[YW-1:0], xs[XW-1:0]};
                  state_in = ST_READ;
               end
               FUNC_LINE: begin
                  sx_in = xs < xe; sy_in = ys < ye;
                  dx_in = (xs < xe) ? xe - xs : xs - xe;
                  dy_in = (ys < ye) ? ye - ys : ys - ye;
                  xmaj_in = dx_in > dy_in;
                  err_in = xmaj_in ? (SW+3)'(2 * dy_in - dx_in)
                                   : (SW+3)'(2 * dx_in - dy_in);
                  state_in = ST_LINE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_BOX: begin
            mcmd.wr = !circ_ff || (d2 <= 28'(lim_ff));
            if (x_ff + 1 < x1_ff) begin
               x_in = x_ff + 1;
            end else begin
               x_in = x0_ff;
               y_in = y_ff + 1;
               if (y_ff + 1 >= y1_ff) state_in = ST_DONE;
            end
         end
         ST_LINE: begin
            if (xmaj_ff ? ((SW+1)'(x_ff) == xe) : ((SW+1)'(y_ff) == ye)) begin
               state_in = ST_DONE;
            end else begin
               mcmd.wr = in_img;
               if (xmaj_ff) begin
                  if (err_ff > 0) begin
                     y_in = sy_ff ? y_ff + 1 : y_ff - 1;
                     err_in = err_ff - (SW+3)'(2 * dx_ff) + (SW+3)'(2 * dy_ff);
                  end else begin
                     err_in = err_ff + (SW+3)'(2 * dy_ff);
                  end
                  x_in = sx_ff ? x_ff + 1 : x_ff - 1;
               end else begin
                  if (err_ff > 0) begin
                     x_in = sx_ff ? x_ff + 1 : x_ff - 1;
                     err_in = err_ff - (SW+3)'(2 * dy_ff) + (SW+3)'(2 * dx_ff);
                  end else begin
                     err_in = err_ff + (SW+3)'(2 * dx_ff);
                  end
                  y_in = sy_ff ? y_ff + 1 : y_ff - 1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = (cmd_ff.func == FUNC_GET && get_ok_ff) ? rdata : '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff <= DIM_W'(MaxWidth);
         height_ff <= DIM_W'(MaxHeight);
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_WIDTH) width_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_HEIGHT) height_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      x_ff <= x_in; y_ff <= y_in; x0_ff <= x0_in; x1_ff <= x1_in; y1_ff <= y1_in;
      err_ff <= err_in; dx_ff <= dx_in; dy_ff <= dy_in;
      sx_ff <= sx_in; sy_ff <= sy_in; xmaj_ff <= xmaj_in; circ_ff <= circ_in;
      lim_ff <= lim_in; get_ok_ff <= get_ok_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

// ===== dv/framebuffer_draw_engine_core_test.sv =====
// testbench for framebuffer_draw_engine_core: drives drawing commands and checks
// every response against a pixel-store predictor held in a small scoreboard class
// depends on fde_pkg, fde_if and the core
`timescale 1ns / 1ps
module framebuffer_draw_engine_core_test;
   import fde_pkg::*;

   localparam int STALL_LIMIT = 400000;

   class draw_scoreboard;
      logic [PIX_W-1:0] pixels [MaxWidth*MaxHeight];
      rsp_type          pending_rsp [$];
      int unsigned      width_reg = 256;
      int unsigned      height_reg = 256;
      int               mismatches = 0;
      int               rsp_count = 0;

      function int act_w();
         return (width_reg > MaxWidth) ? MaxWidth : width_reg;
      endfunction

      function int act_h();
         return (height_reg > MaxHeight) ? MaxHeight : height_reg;
      endfunction

      function void write_reg(logic [CSR_AW-1:0] idx, logic [DIM_W-1:0] val);
         if (idx == CSR_WIDTH) width_reg = val;
         else if (idx == CSR_HEIGHT) height_reg = val;
      endfunction

      function void put_pixel(int x, int y, logic [PIX_W-1:0] rgb);
         if (x >= 0 && x < act_w() && y >= 0 && y < act_h())
            pixels[y*MaxWidth + x] = rgb;
      endfunction

      function void paint_box(int x0, int y0, int x1, int y1, logic [PIX_W-1:0] rgb);
         if (x0 < 0) x0 = 0;
         if (y0 < 0) y0 = 0;
         if (x1 > act_w()) x1 = act_w();
         if (y1 > act_h()) y1 = act_h();
         for (int y = y0; y < y1; y++)
            for (int x = x0; x < x1; x++) pixels[y*MaxWidth + x] = rgb;
      endfunction

      function void paint_disc(int cx, int cy, int r, logic [PIX_W-1:0] rgb);
         int x0, y0, x1, y1;
         longint lim, rx, ry;
         x0 = cx - r; y0 = cy - r; x1 = cx + r + 1; y1 = cy + r + 1;
         lim = longint'(r) * r;
         if (x0 < 0) x0 = 0;
         if (y0 < 0) y0 = 0;
         if (x1 > act_w()) x1 = act_w();
         if (y1 > act_h()) y1 = act_h();
         for (int y = y0; y < y1; y++)
            for (int x = x0; x < x1; x++) begin
               rx = x - cx;
               ry = y - cy;
               if (rx*rx + ry*ry <= lim) pixels[y*MaxWidth + x] = rgb;
            end
      endfunction

      function void trace_line(int xa, int ya, int xb, int yb, logic [PIX_W-1:0] rgb);
         int x, y, dx, dy, sx, sy, err;
         x = xa; y = ya;
         if (xa < xb) begin dx = xb - xa; sx = 1; end else begin dx = xa - xb; sx = -1; end
         if (ya < yb) begin dy = yb - ya; sy = 1; end else begin dy = ya - yb; sy = -1; end
         if (dx > dy) begin
            err = 2*dy - dx;
            while (x != xb) begin
               put_pixel(x, y, rgb);
               if (err > 0) begin y += sy; err -= 2*dx; end
               err += 2*dy;
               x += sx;
            end
         end else begin
            err = 2*dx - dy;
            while (y != yb) begin
               put_pixel(x, y, rgb);
               if (err > 0) begin x += sx; err -= 2*dy; end
               err += 2*dx;
               y += sy;
            end
         end
      endfunction

      function void note_request(req_type r);
         int xs, ys, xe, ye, ew, eh;
         logic [PIX_W-1:0] rgb, rd;
         rsp_type e;
         xs = $signed(r.x_start); ys = $signed(r.y_start);
         xe = $signed(r.x_end);   ye = $signed(r.y_end);
         ew = r.extent_width;     eh = r.extent_height;
         rgb = {r.fill_red, r.fill_green, r.fill_blue};
         rd = '0;
         case (r.func)
            FUNC_CLEAR: paint_box(0, 0, act_w(), act_h(), rgb);
            FUNC_SET:   put_pixel(xs, ys, rgb);
            FUNC_GET:
               if (xs >= 0 && xs < act_w() && ys >= 0 && ys < act_h())
                  rd = pixels[ys*MaxWidth + xs];
            FUNC_RECT:  paint_box(xs, ys, xs + ew, ys + eh, rgb);
            FUNC_CIRC:  paint_disc(xs, ys, ew, rgb);
            FUNC_LINE:  trace_line(xs, ys, xe, ye, rgb);
            default: ;
         endcase
         e.read_red = rd[23:16];
         e.read_green = rd[15:8];
         e.read_blue = rd[7:0];
         pending_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         e = pending_rsp.pop_front();
         if (got.read_red !== e.read_red || got.read_green !== e.read_green ||
             got.read_blue !== e.read_blue) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                        rsp_count, e.read_red, e.read_green, e.read_blue,
                        got.read_red, got.read_green, got.read_blue);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_wdata = '0;

   fde_req_if req_ch();
   fde_rsp_if rsp_ch();

   framebuffer_draw_engine_core dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   draw_scoreboard sb = new();
   int send_idle_pct = 30;
   int recv_idle_pct = 61;
   int hold_left = 0;
   bit hold_done = 0;
   int quiet_cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   // response side: check, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
      if (!hold_done && sb.rsp_count == 150) begin
         hold_left = 600;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain_and_configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1; csr_index <= CSR_WIDTH; csr_wdata <= w;
      @(posedge clock);
      sb.write_reg(CSR_WIDTH, w);
      csr_index <= CSR_HEIGHT; csr_wdata <= h;
      @(posedge clock);
      sb.write_reg(CSR_HEIGHT, h);
      csr_we <= 0;
   endtask

   function automatic req_type make_cmd(logic [2:0] f, int xs, int ys, int xe, int ye,
                                        int ew, int eh, logic [23:0] rgb);
      req_type r;
      r.func = f;
      r.x_start = CW'(xs); r.y_start = CW'(ys); r.x_end = CW'(xe); r.y_end = CW'(ye);
      r.extent_width = CW'(ew); r.extent_height = CW'(eh);
      {r.fill_red, r.fill_green, r.fill_blue} = rgb;
      return r;
   endfunction

   function automatic int pick_coord(int lim);
      if ($urandom_range(99) < 10) return $signed(12'($urandom));
      return $urandom_range(lim + 8) - 4;
   endfunction

   function automatic req_type random_cmd(int aw, int ah);
      req_type r;
      int p;
      logic [2:0] f;
      p = $urandom_range(99);
      if (p < 2) f = 3'($urandom_range(7, 6));
      else if (p < 5 && aw*ah <= 4096) f = FUNC_CLEAR;
      else if (p < 30) f = FUNC_GET;
      else if (p < 45) f = FUNC_SET;
      else if (p < 65) f = FUNC_RECT;
      else if (p < 80) f = FUNC_CIRC;
      else f = FUNC_LINE;
      r = make_cmd(f, pick_coord(aw), pick_coord(ah), pick_coord(aw), pick_coord(ah),
                   ($urandom_range(99) < 8) ? $urandom_range(4095) : $urandom_range(24),
                   ($urandom_range(99) < 8) ? $urandom_range(4095) : $urandom_range(24),
                   24'($urandom));
      return r;
   endfunction

   int widths  [8] = '{256, 1, 0, 511, 40, 256, 7, 100};
   int heights [8] = '{256, 1, 9, 3, 30, 2, 256, 64};

   initial begin
      int sent;
      int aw, ah;
      sent = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed requests on the full 256 x 256 image
      drain_and_configure(DIM_W'(256), DIM_W'(256));
      send_request(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 24'h123456));
      send_request(make_cmd(FUNC_GET, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_cmd(FUNC_SET, 255, 255, 0, 0, 0, 0, 24'hffffff));
      send_request(make_cmd(FUNC_GET, 255, 255, 0, 0, 0, 0, 0));
      send_request(make_cmd(FUNC_SET, -2048, 2047, 0, 0, 0, 0, 24'hff00ff));
      send_request(make_cmd(FUNC_GET, 256, 0, 0, 0, 0, 0, 0));
      send_request(make_cmd(FUNC_GET, -1, -2048, 0, 0, 0, 0, 0));
      send_request(make_cmd(FUNC_RECT, 10, 10, 0, 0, 0, 5, 24'h0000ff));
      send_request(make_cmd(FUNC_RECT, -2048, 250, 0, 0, 4095, 4095, 24'h00ff00));
      send_request(make_cmd(FUNC_GET, 3, 253, 0, 0, 0, 0, 0));
      send_request(make_cmd(FUNC_CIRC, 50, 50, 0, 0, 0, 0, 24'habcdef));
      send_request(make_cmd(FUNC_CIRC, 60, 40, 0, 0, 6, 0, 24'h808080));
      send_request(make_cmd(FUNC_GET, 66, 40, 0, 0, 0, 0, 0));
      send_request(make_cmd(FUNC_LINE, 20, 20, 20, 20, 0, 0, 24'h111111));
      send_request(make_cmd(FUNC_LINE, 0, 0, 30, 7, 0, 0, 24'h222222));
      send_request(make_cmd(FUNC_LINE, 30, 7, 0, 0, 0, 0, 24'h333333));
      send_request(make_cmd(FUNC_LINE, 5, 40, 9, 0, 0, 0, 24'h444444));
      send_request(make_cmd(FUNC_LINE, 9, 0, 5, 40, 0, 0, 24'h555555));
      send_request(make_cmd(FUNC_LINE, -2048, 100, 2047, 100, 0, 0, 24'h666666));
      send_request(make_cmd(FUNC_GET, 30, 7, 0, 0, 0, 0, 0));
      send_request(make_cmd(FUNC_GET, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_cmd(3'd6, 1, 1, 1, 1, 1, 1, 24'h777777));
      send_request(make_cmd(3'd7, 1, 1, 1, 1, 1, 1, 24'h777777));

      for (int ph = 0; ph < 8; ph++) begin
         drain_and_configure(DIM_W'(widths[ph]), DIM_W'(heights[ph]));
         aw = sb.act_w();
         ah = sb.act_h();
         send_request(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 24'($urandom)));
         for (int i = 0; i < 50; i++) begin
            if (sent < 133) begin
               send_idle_pct = 30; recv_idle_pct = 61;
            end else if (sent < 266) begin
               send_idle_pct = 61; recv_idle_pct = 30;
            end else begin
               send_idle_pct = 0; recv_idle_pct = 0;
            end
            send_request(random_cmd(aw, ah));
            sent++;
         end
      end

      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
